@@ rtl/ptzenc_pkg.sv @@
// Package with the shared types, constants and the opcode table of the camera frame encoder.
`default_nettype none
package ptzenc_pkg;

  localparam int unsigned OpWidth   = 6;
  localparam int unsigned ArgWidth  = 16;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned IdxWidth  = 3;

  localparam logic [OpWidth-1:0]   OpCount    = 6'd53;
  localparam logic [ByteWidth-1:0] SyncByte   = 8'hff;
  localparam logic [ArgWidth-1:0]  AngleMax   = 16'd35999;
  localparam logic [ByteWidth-1:0] DefaultAddr = 8'd1;

  localparam logic [IdxWidth-1:0] IdxSync  = 3'd0;
  localparam logic [IdxWidth-1:0] IdxAddr  = 3'd1;
  localparam logic [IdxWidth-1:0] IdxCmd1  = 3'd2;
  localparam logic [IdxWidth-1:0] IdxCmd2  = 3'd3;
  localparam logic [IdxWidth-1:0] IdxData1 = 3'd4;
  localparam logic [IdxWidth-1:0] IdxData2 = 3'd5;
  localparam logic [IdxWidth-1:0] IdxSum   = 3'd6;

  typedef enum logic [3:0] {
    KIND_ZERO,
    KIND_PAN,
    KIND_TILT,
    KIND_BOTH,
    KIND_ID,
    KIND_FIX,
    KIND_COL,
    KIND_POS,
    KIND_WORD
  } kind_e;

  typedef struct packed {
    logic [ByteWidth-1:0] c1;
    logic [ByteWidth-1:0] c2;
    kind_e                kind;
    logic [ByteWidth-1:0] lo;
    logic [ByteWidth-1:0] hi;
  } op_entry_t;

  typedef struct packed {
    logic [ByteWidth-1:0] c1;
    logic [ByteWidth-1:0] c2;
    logic [ByteWidth-1:0] d1;
    logic [ByteWidth-1:0] d2;
  } frame_t;

  function automatic op_entry_t mk(input logic [7:0] c1, input logic [7:0] c2,
                                   input kind_e kind, input logic [7:0] lo,
                                   input logic [7:0] hi);
    op_entry_t e;
    e.c1   = c1;
    e.c2   = c2;
    e.kind = kind;
    e.lo   = lo;
    e.hi   = hi;
    return e;
  endfunction

  function automatic op_entry_t op_lookup(input logic [OpWidth-1:0] op);
    op_entry_t e;
    unique case (op)
      6'd0:  e = mk(8'h00, 8'h04, KIND_PAN,  8'h00, 8'h3f);
      6'd1:  e = mk(8'h00, 8'h02, KIND_PAN,  8'h00, 8'h3f);
      6'd2:  e = mk(8'h00, 8'h08, KIND_TILT, 8'h00, 8'h3f);
      6'd3:  e = mk(8'h00, 8'h10, KIND_TILT, 8'h00, 8'h3f);
      6'd4:  e = mk(8'h00, 8'h0C, KIND_BOTH, 8'h00, 8'h3f);
      6'd5:  e = mk(8'h00, 8'h0A, KIND_BOTH, 8'h00, 8'h3f);
      6'd6:  e = mk(8'h00, 8'h14, KIND_BOTH, 8'h00, 8'h3f);
      6'd7:  e = mk(8'h00, 8'h12, KIND_BOTH, 8'h00, 8'h3f);
      6'd8:  e = mk(8'h00, 8'h00, KIND_ZERO, 8'h00, 8'h00);
      6'd9:  e = mk(8'h01, 8'h00, KIND_ZERO, 8'h00, 8'h00);
      6'd10: e = mk(8'h00, 8'h80, KIND_ZERO, 8'h00, 8'h00);
      6'd11: e = mk(8'h00, 8'h20, KIND_ZERO, 8'h00, 8'h00);
      6'd12: e = mk(8'h00, 8'h40, KIND_ZERO, 8'h00, 8'h00);
      6'd13: e = mk(8'h04, 8'h00, KIND_ZERO, 8'h00, 8'h00);
      6'd14: e = mk(8'h02, 8'h00, KIND_ZERO, 8'h00, 8'h00);
      6'd15: e = mk(8'h08, 8'h00, KIND_ZERO, 8'h00, 8'h00);
      6'd16: e = mk(8'h00, 8'h00, KIND_ZERO, 8'h00, 8'h00);
      6'd17: e = mk(8'h00, 8'h03, KIND_ID,   8'h00, 8'hff);
      6'd18: e = mk(8'h00, 8'h05, KIND_ID,   8'h00, 8'hff);
      6'd19: e = mk(8'h00, 8'h07, KIND_ID,   8'h00, 8'hff);
      6'd20: e = mk(8'h00, 8'h07, KIND_FIX,  8'h21, 8'h00);
      6'd21: e = mk(8'h00, 8'h07, KIND_FIX,  8'h22, 8'h00);
      6'd22: e = mk(8'h00, 8'h09, KIND_ID,   8'h01, 8'h08);
      6'd23: e = mk(8'h00, 8'h0B, KIND_ID,   8'h01, 8'h08);
      6'd24: e = mk(8'h00, 8'h0F, KIND_ZERO, 8'h00, 8'h00);
      6'd25: e = mk(8'h00, 8'h11, KIND_ID,   8'h01, 8'h08);
      6'd26: e = mk(8'h00, 8'h13, KIND_ID,   8'h01, 8'h08);
      6'd27: e = mk(8'h00, 8'h15, KIND_COL,  8'h00, 8'h27);
      6'd28: e = mk(8'h00, 8'h17, KIND_ZERO, 8'h00, 8'h00);
      6'd29: e = mk(8'h00, 8'h19, KIND_ID,   8'h01, 8'h08);
      6'd30: e = mk(8'h00, 8'h1B, KIND_ZERO, 8'h00, 8'h00);
      6'd31: e = mk(8'h00, 8'h1D, KIND_ZERO, 8'h00, 8'h00);
      6'd32: e = mk(8'h00, 8'h1F, KIND_ID,   8'h01, 8'h04);
      6'd33: e = mk(8'h00, 8'h21, KIND_ZERO, 8'h00, 8'h00);
      6'd34: e = mk(8'h00, 8'h23, KIND_ID,   8'h01, 8'h04);
      6'd35: e = mk(8'h00, 8'h25, KIND_ID,   8'h00, 8'h03);
      6'd36: e = mk(8'h00, 8'h27, KIND_ID,   8'h00, 8'h03);
      6'd37: e = mk(8'h00, 8'h29, KIND_ZERO, 8'h00, 8'h00);
      6'd38: e = mk(8'h00, 8'h2B, KIND_ID,   8'h00, 8'h02);
      6'd39: e = mk(8'h00, 8'h2D, KIND_ID,   8'h00, 8'h02);
      6'd40: e = mk(8'h00, 8'h2F, KIND_ID,   8'h00, 8'h02);
      6'd41: e = mk(8'h00, 8'h31, KIND_ID,   8'h01, 8'h02);
      6'd42: e = mk(8'h00, 8'h33, KIND_ID,   8'h01, 8'h02);
      6'd43: e = mk(8'h00, 8'h35, KIND_ZERO, 8'h00, 8'h00);
      6'd44: e = mk(8'h00, 8'h49, KIND_ZERO, 8'h00, 8'h00);
      6'd45: e = mk(8'h00, 8'h4B, KIND_POS,  8'h00, 8'h00);
      6'd46: e = mk(8'h00, 8'h4D, KIND_POS,  8'h00, 8'h00);
      6'd47: e = mk(8'h00, 8'h4F, KIND_WORD, 8'h00, 8'h00);
      6'd48: e = mk(8'h00, 8'h51, KIND_ZERO, 8'h00, 8'h00);
      6'd49: e = mk(8'h00, 8'h53, KIND_ZERO, 8'h00, 8'h00);
      6'd50: e = mk(8'h00, 8'h55, KIND_ZERO, 8'h00, 8'h00);
      6'd51: e = mk(8'h00, 8'h5F, KIND_WORD, 8'h00, 8'h00);
      6'd52: e = mk(8'h00, 8'h61, KIND_ZERO, 8'h00, 8'h00);
      default: e = mk(8'h00, 8'h00, KIND_ZERO, 8'h00, 8'h00);
    endcase
    return e;
  endfunction

  function automatic logic [ByteWidth-1:0] clamp_byte(input logic [ByteWidth-1:0] v,
                                                      input logic [ByteWidth-1:0] lo,
                                                      input logic [ByteWidth-1:0] hi);
    logic [ByteWidth-1:0] r;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/ptzenc_cmd_if.sv @@
// Command channel interface: valid, ready and one command request per beat.
`default_nettype none
interface ptzenc_cmd_if;
  logic        valid;
  logic        ready;
  logic [5:0]  op;
  logic [15:0] arg_main;
  logic [7:0]  arg_char;
  logic        clamp_angle;

  modport source (output valid, output op, output arg_main, output arg_char,
                  output clamp_angle, input ready);
  modport sink (input valid, input op, input arg_main, input arg_char,
                input clamp_angle, output ready);
endinterface
`default_nettype wire

@@ rtl/ptzenc_byte_if.sv @@
// Byte channel interface: valid, ready and one frame byte with its last flag per beat.
`default_nettype none
interface ptzenc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink (input valid, input out_byte, input last_byte, output ready);
endinterface
`default_nettype wire

@@ rtl/ptz_command_frame_encoder.sv @@
// Top level of the camera command frame encoder.
//
// A command beat on cmd_i (op, arg_main, arg_char, clamp_angle) produces one
// seven-byte frame on frame_o: sync, device address, command 1, command 2,
// data 1, data 2 and checksum, one byte per beat, with last_byte set on the
// checksum. Opcodes above the table are accepted and produce no bytes.
// The device address is written through cfg_we_i and cfg_data_i and resets
// to one. Write it only while the block is idle; this is not enforced.
// A frame passes the front stage register, the queue and the back end's
// frame register before its first byte reaches the output register. The
// output sends one byte per cycle unless the receiver stalls, with no gap
// between frames while the queue holds the next. The front stage and the
// two-entry queue buffer up to three commands ahead of the frame being
// sent, so commands are taken during a stall until that space is used.
// Reset empties the pipeline and the queue; no byte is lost when the
// receiver holds ready low, the output beat simply waits.
`default_nettype none
module ptz_command_frame_encoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_data_i,
  ptzenc_cmd_if.sink      cmd_i,
  ptzenc_byte_if.source   frame_o
);
  import ptzenc_pkg::*;

  logic [ByteWidth-1:0] addr_q, addr_d;
  frame_t front_frame;
  frame_t queue_frame;
  logic   push;
  logic   full;
  logic   pop;
  logic   empty;

  assign addr_d = cfg_we_i ? cfg_data_i : addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= DefaultAddr;
    end else begin
      addr_q <= addr_d;
    end
  end

  ptzenc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_i),
    .frame_o (front_frame),
    .push_o  (push),
    .full_i  (full)
  );

  ptzenc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_frame),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (queue_frame),
    .empty_o (empty)
  );

  ptzenc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .addr_i  (addr_q),
    .frame_i (queue_frame),
    .empty_i (empty),
    .pop_o   (pop),
    .byte_o  (frame_o)
  );
endmodule
`default_nettype wire

@@ rtl/ptzenc_front.sv @@
// Front end: accepts command beats, looks up the opcode and clamps the arguments.
`default_nettype none
module ptzenc_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  ptzenc_cmd_if.sink            cmd_i,
  output ptzenc_pkg::frame_t    frame_o,
  output logic                  push_o,
  input  wire logic             full_i
);
  import ptzenc_pkg::*;

  logic      valid_q, valid_d;
  frame_t    frame_q, frame_d;
  op_entry_t entry;
  logic [ByteWidth-1:0] low;
  logic [ByteWidth-1:0] lim;
  logic [ArgWidth-1:0]  pos;
  logic                 accept;

  assign push_o      = valid_q && !full_i;
  assign cmd_i.ready = !valid_q || !full_i;
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign frame_o     = frame_q;

  always_comb begin
    entry = op_lookup(cmd_i.op);
    low   = cmd_i.arg_main[ByteWidth-1:0];
    lim   = clamp_byte(low, entry.lo, entry.hi);
    pos   = (cmd_i.clamp_angle && (cmd_i.arg_main > AngleMax)) ? AngleMax : cmd_i.arg_main;
    frame_d.c1 = entry.c1;
    frame_d.c2 = entry.c2;
    frame_d.d1 = '0;
    frame_d.d2 = '0;
    unique case (entry.kind)
      KIND_PAN:  frame_d.d1 = lim;
      KIND_TILT: frame_d.d2 = lim;
      KIND_BOTH: begin
        frame_d.d1 = lim;
        frame_d.d2 = lim;
      end
      KIND_ID:   frame_d.d2 = lim;
      KIND_FIX:  frame_d.d2 = entry.lo;
      KIND_COL: begin
        frame_d.d1 = lim;
        frame_d.d2 = cmd_i.arg_char;
      end
      KIND_POS: begin
        frame_d.d1 = pos[ArgWidth-1:ByteWidth];
        frame_d.d2 = pos[ByteWidth-1:0];
      end
      KIND_WORD: begin
        frame_d.d1 = cmd_i.arg_main[ArgWidth-1:ByteWidth];
        frame_d.d2 = cmd_i.arg_main[ByteWidth-1:0];
      end
      default: ;
    endcase

    valid_d = valid_q;
    if (accept) begin
      // Unknown opcodes are taken and dropped.
      valid_d = cmd_i.op < OpCount;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      frame_q <= frame_d;
    end
  end
endmodule
`default_nettype wire

@@ rtl/ptzenc_queue.sv @@
// Two-entry queue of classified frames between the front and back ends.
`default_nettype none
module ptzenc_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire ptzenc_pkg::frame_t wdata_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output ptzenc_pkg::frame_t      rdata_o,
  output logic                    empty_o
);
  import ptzenc_pkg::*;

  frame_t     mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = count_q == 2'd2;
  assign empty_o = count_q == 2'd0;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end
endmodule
`default_nettype wire

@@ rtl/ptzenc_back.sv @@
// Back end: serializes one frame into seven byte beats with the checksum last.
`default_nettype none
module ptzenc_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [7:0]         addr_i,
  input  wire ptzenc_pkg::frame_t frame_i,
  input  wire logic               empty_i,
  output logic                    pop_o,
  ptzenc_byte_if.source           byte_o
);
  import ptzenc_pkg::*;

  logic                 busy_q, busy_d;
  logic [IdxWidth-1:0]  idx_q, idx_d;
  frame_t               cur_q;
  logic [ByteWidth-1:0] sum_q;
  logic                 ovalid_q, ovalid_d;
  logic [ByteWidth-1:0] obyte_q, obyte_d;
  logic                 olast_q, olast_d;
  logic                 adv;
  logic                 emit;

  assign adv   = !ovalid_q || byte_o.ready;
  assign emit  = adv && busy_q;
  assign pop_o = adv && (!busy_q || (idx_q == IdxSum)) && !empty_i;

  assign byte_o.valid     = ovalid_q;
  assign byte_o.out_byte  = obyte_q;
  assign byte_o.last_byte = olast_q;

  always_comb begin
    busy_d   = busy_q;
    idx_d    = idx_q;
    ovalid_d = ovalid_q;
    obyte_d  = obyte_q;
    olast_d  = olast_q;
    if (adv) begin
      ovalid_d = busy_q;
    end
    if (emit) begin
      olast_d = idx_q == IdxSum;
      unique case (idx_q)
        IdxSync:  obyte_d = SyncByte;
        IdxAddr:  obyte_d = addr_i;
        IdxCmd1:  obyte_d = cur_q.c1;
        IdxCmd2:  obyte_d = cur_q.c2;
        IdxData1: obyte_d = cur_q.d1;
        IdxData2: obyte_d = cur_q.d2;
        IdxSum:   obyte_d = sum_q;
        default:  obyte_d = '0;
      endcase
      if (idx_q == IdxSum) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end
    if (pop_o) begin
      busy_d = 1'b1;
      idx_d  = IdxSync;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      idx_q    <= IdxSync;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obyte_q <= obyte_d;
    olast_q <= olast_d;
    if (pop_o) begin
      cur_q <= frame_i;
      sum_q <= addr_i + frame_i.c1 + frame_i.c2 + frame_i.d1 + frame_i.d2;
    end
  end
endmodule
`default_nettype wire

@@ dv/ptz_command_frame_encoder_test.sv @@
// Self-checking testbench for the camera command frame encoder with randomized flow control.
`default_nettype none
module ptz_command_frame_encoder_test;
  import ptzenc_pkg::*;

  typedef struct {
    logic [OpWidth-1:0]   op;
    logic [ArgWidth-1:0]  arg;
    logic [ByteWidth-1:0] ch;
    logic                 clamp;
  } command_t;

  typedef struct {
    logic [ByteWidth-1:0] data;
    logic                 last;
  } frame_byte_t;

  typedef struct {
    logic [ByteWidth-1:0] c1;
    logic [ByteWidth-1:0] c2;
    kind_e                kind;
    logic [ByteWidth-1:0] lo;
    logic [ByteWidth-1:0] hi;
  } cmd_row_t;

  localparam int HoldCycles  = 80;
  localparam int IdleLimit   = 1000;
  localparam int DrainCycles = 12;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [ByteWidth-1:0] cfg_data;

  ptzenc_cmd_if  cmd_bus ();
  ptzenc_byte_if frame_bus ();

  ptz_command_frame_encoder dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .cmd_i      (cmd_bus),
    .frame_o    (frame_bus)
  );

  command_t             cmd_q[$];
  frame_byte_t          frame_bytes_q[$];
  command_t             next_cmd;
  command_t             accepted_cmd;
  frame_byte_t          want_byte;
  logic [ByteWidth-1:0] dev_addr;
  int                   send_idle;
  int                   recv_idle;
  int                   errors;
  logic                 hold_go;
  int                   hold_left;
  int                   quiet_cycles;

  function automatic cmd_row_t lookup_row(input logic [OpWidth-1:0] op);
    cmd_row_t r;
    case (op)
      6'd0:  r = '{8'h00, 8'h04, KIND_PAN,  8'h00, 8'h3f};
      6'd1:  r = '{8'h00, 8'h02, KIND_PAN,  8'h00, 8'h3f};
      6'd2:  r = '{8'h00, 8'h08, KIND_TILT, 8'h00, 8'h3f};
      6'd3:  r = '{8'h00, 8'h10, KIND_TILT, 8'h00, 8'h3f};
      6'd4:  r = '{8'h00, 8'h0C, KIND_BOTH, 8'h00, 8'h3f};
      6'd5:  r = '{8'h00, 8'h0A, KIND_BOTH, 8'h00, 8'h3f};
      6'd6:  r = '{8'h00, 8'h14, KIND_BOTH, 8'h00, 8'h3f};
      6'd7:  r = '{8'h00, 8'h12, KIND_BOTH, 8'h00, 8'h3f};
      6'd9:  r = '{8'h01, 8'h00, KIND_ZERO, 8'h00, 8'h00};
      6'd10: r = '{8'h00, 8'h80, KIND_ZERO, 8'h00, 8'h00};
      6'd11: r = '{8'h00, 8'h20, KIND_ZERO, 8'h00, 8'h00};
      6'd12: r = '{8'h00, 8'h40, KIND_ZERO, 8'h00, 8'h00};
      6'd13: r = '{8'h04, 8'h00, KIND_ZERO, 8'h00, 8'h00};
      6'd14: r = '{8'h02, 8'h00, KIND_ZERO, 8'h00, 8'h00};
      6'd15: r = '{8'h08, 8'h00, KIND_ZERO, 8'h00, 8'h00};
      6'd17: r = '{8'h00, 8'h03, KIND_ID,   8'h00, 8'hff};
      6'd18: r = '{8'h00, 8'h05, KIND_ID,   8'h00, 8'hff};
      6'd19: r = '{8'h00, 8'h07, KIND_ID,   8'h00, 8'hff};
      6'd20: r = '{8'h00, 8'h07, KIND_FIX,  8'h21, 8'h00};
      6'd21: r = '{8'h00, 8'h07, KIND_FIX,  8'h22, 8'h00};
      6'd22: r = '{8'h00, 8'h09, KIND_ID,   8'h01, 8'h08};
      6'd23: r = '{8'h00, 8'h0B, KIND_ID,   8'h01, 8'h08};
      6'd24: r = '{8'h00, 8'h0F, KIND_ZERO, 8'h00, 8'h00};
      6'd25: r = '{8'h00, 8'h11, KIND_ID,   8'h01, 8'h08};
      6'd26: r = '{8'h00, 8'h13, KIND_ID,   8'h01, 8'h08};
      6'd27: r = '{8'h00, 8'h15, KIND_COL,  8'h00, 8'h27};
      6'd28: r = '{8'h00, 8'h17, KIND_ZERO, 8'h00, 8'h00};
      6'd29: r = '{8'h00, 8'h19, KIND_ID,   8'h01, 8'h08};
      6'd30: r = '{8'h00, 8'h1B, KIND_ZERO, 8'h00, 8'h00};
      6'd31: r = '{8'h00, 8'h1D, KIND_ZERO, 8'h00, 8'h00};
      6'd32: r = '{8'h00, 8'h1F, KIND_ID,   8'h01, 8'h04};
      6'd33: r = '{8'h00, 8'h21, KIND_ZERO, 8'h00, 8'h00};
      6'd34: r = '{8'h00, 8'h23, KIND_ID,   8'h01, 8'h04};
      6'd35: r = '{8'h00, 8'h25, KIND_ID,   8'h00, 8'h03};
      6'd36: r = '{8'h00, 8'h27, KIND_ID,   8'h00, 8'h03};
      6'd37: r = '{8'h00, 8'h29, KIND_ZERO, 8'h00, 8'h00};
      6'd38: r = '{8'h00, 8'h2B, KIND_ID,   8'h00, 8'h02};
      6'd39: r = '{8'h00, 8'h2D, KIND_ID,   8'h00, 8'h02};
      6'd40: r = '{8'h00, 8'h2F, KIND_ID,   8'h00, 8'h02};
      6'd41: r = '{8'h00, 8'h31, KIND_ID,   8'h01, 8'h02};
      6'd42: r = '{8'h00, 8'h33, KIND_ID,   8'h01, 8'h02};
      6'd43: r = '{8'h00, 8'h35, KIND_ZERO, 8'h00, 8'h00};
      6'd44: r = '{8'h00, 8'h49, KIND_ZERO, 8'h00, 8'h00};
      6'd45: r = '{8'h00, 8'h4B, KIND_POS,  8'h00, 8'h00};
      6'd46: r = '{8'h00, 8'h4D, KIND_POS,  8'h00, 8'h00};
      6'd47: r = '{8'h00, 8'h4F, KIND_WORD, 8'h00, 8'h00};
      6'd48: r = '{8'h00, 8'h51, KIND_ZERO, 8'h00, 8'h00};
      6'd49: r = '{8'h00, 8'h53, KIND_ZERO, 8'h00, 8'h00};
      6'd50: r = '{8'h00, 8'h55, KIND_ZERO, 8'h00, 8'h00};
      6'd51: r = '{8'h00, 8'h5F, KIND_WORD, 8'h00, 8'h00};
      6'd52: r = '{8'h00, 8'h61, KIND_ZERO, 8'h00, 8'h00};
      default: r = '{8'h00, 8'h00, KIND_ZERO, 8'h00, 8'h00};
    endcase
    return r;
  endfunction

  function automatic void push_frame_bytes(input command_t c);
    cmd_row_t             r;
    logic [ByteWidth-1:0] low;
    logic [ByteWidth-1:0] clamped;
    logic [ByteWidth-1:0] d1;
    logic [ByteWidth-1:0] d2;
    logic [ArgWidth-1:0]  pos;
    logic [ByteWidth-1:0] bytes [7];
    frame_byte_t          fb;
    if (c.op >= OpCount) begin
      return;
    end
    r   = lookup_row(c.op);
    low = c.arg[7:0];
    d1  = '0;
    d2  = '0;
    if (low > r.hi) begin
      clamped = r.hi;
    end else if (low < r.lo) begin
      clamped = r.lo;
    end else begin
      clamped = low;
    end
    case (r.kind)
      KIND_PAN: begin
        d1 = clamped;
      end
      KIND_TILT, KIND_ID: begin
        d2 = clamped;
      end
      KIND_BOTH: begin
        d1 = clamped;
        d2 = clamped;
      end
      KIND_FIX: begin
        d2 = r.lo;
      end
      KIND_COL: begin
        d1 = clamped;
        d2 = c.ch;
      end
      KIND_POS: begin
        pos = (c.clamp && c.arg > AngleMax) ? AngleMax : c.arg;
        d1  = pos[15:8];
        d2  = pos[7:0];
      end
      KIND_WORD: begin
        d1 = c.arg[15:8];
        d2 = c.arg[7:0];
      end
      default: begin
      end
    endcase
    bytes[0] = SyncByte;
    bytes[1] = dev_addr;
    bytes[2] = r.c1;
    bytes[3] = r.c2;
    bytes[4] = d1;
    bytes[5] = d2;
    bytes[6] = dev_addr + r.c1 + r.c2 + d1 + d2;
    for (int k = 0; k < 7; k++) begin
      fb.data = bytes[k];
      fb.last = (k == 6);
      frame_bytes_q.insert(frame_bytes_q.size(), fb);
    end
  endfunction

  function automatic command_t random_command();
    command_t             c;
    logic [ByteWidth-1:0] edge_vals [13] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd8, 8'd9,
                                             8'd39, 8'd40, 8'd63, 8'd64, 8'd255};
    if ($urandom_range(99) < 8) begin
      c.op = 6'($urandom_range(63, 53));
    end else begin
      c.op = 6'($urandom_range(52, 0));
    end
    case ($urandom_range(3))
      0: c.arg = 16'($urandom);
      1: c.arg = {8'($urandom), edge_vals[$urandom_range(12)]};
      2: c.arg = 16'($urandom_range(36100, 35900));
      default: c.arg = 16'($urandom_range(65535, 65500));
    endcase
    c.ch    = 8'($urandom);
    c.clamp = 1'($urandom);
    return c;
  endfunction

  task automatic add_cmd(input int op, input int arg, input int ch, input bit clamp);
    command_t c;
    c.op    = 6'(op);
    c.arg   = 16'(arg);
    c.ch    = 8'(ch);
    c.clamp = clamp;
    cmd_q.insert(cmd_q.size(), c);
  endtask

  task automatic add_random(input int count);
    command_t c;
    int       n;
    n = 0;
    while (n < count) begin
      c = random_command();
      cmd_q.insert(cmd_q.size(), c);
      if (c.op < OpCount) begin
        n++;
      end
    end
  endtask

  task automatic set_address(input logic [ByteWidth-1:0] v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    dev_addr = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (cmd_q.size() != 0 || cmd_bus.valid || frame_bytes_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_bus.valid <= 1'b0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        accepted_cmd = '{cmd_bus.op, cmd_bus.arg_main, cmd_bus.arg_char, cmd_bus.clamp_angle};
        push_frame_bytes(accepted_cmd);
      end
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          next_cmd = cmd_q.pop_front();
          cmd_bus.op          <= next_cmd.op;
          cmd_bus.arg_main    <= next_cmd.arg;
          cmd_bus.arg_char    <= next_cmd.ch;
          cmd_bus.clamp_angle <= next_cmd.clamp;
          cmd_bus.valid       <= 1'b1;
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      frame_bus.ready <= 1'b0;
    end else begin
      frame_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && frame_bus.valid && frame_bus.ready) begin
      if (frame_bytes_q.size() == 0) begin
        $error("out_byte: no beat expected, got %02h", frame_bus.out_byte);
        errors++;
      end else begin
        want_byte = frame_bytes_q.pop_front();
        if (frame_bus.out_byte !== want_byte.data) begin
          $error("out_byte: expected %02h, got %02h", want_byte.data, frame_bus.out_byte);
          errors++;
        end
        if (frame_bus.last_byte !== want_byte.last) begin
          $error("last_byte: expected %0b, got %0b", want_byte.last, frame_bus.last_byte);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((cmd_bus.valid && cmd_bus.ready) || (frame_bus.valid && frame_bus.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_data              = '0;
    cmd_bus.valid         = 1'b0;
    cmd_bus.op            = '0;
    cmd_bus.arg_main      = '0;
    cmd_bus.arg_char      = '0;
    cmd_bus.clamp_angle   = 1'b0;
    frame_bus.ready       = 1'b0;
    hold_go               = 1'b0;
    errors                = 0;
    quiet_cycles          = 0;
    dev_addr              = DefaultAddr;
    send_idle             = 32;
    recv_idle             = 46;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    add_cmd(0, 16'hffff, 8'h00, 1'b0);
    add_cmd(1, 16'h003f, 8'hff, 1'b1);
    add_cmd(2, 16'h0040, 8'h00, 1'b0);
    add_cmd(3, 16'h0000, 8'h00, 1'b0);
    add_cmd(4, 16'h00ff, 8'h00, 1'b0);
    add_cmd(7, 16'h8020, 8'h00, 1'b0);
    add_cmd(8, 16'hffff, 8'hff, 1'b1);
    add_cmd(16, 16'hffff, 8'hff, 1'b1);
    add_cmd(17, 16'hab00, 8'h00, 1'b0);
    add_cmd(19, 16'h00ff, 8'h00, 1'b0);
    add_cmd(20, 16'h1234, 8'h00, 1'b0);
    add_cmd(21, 16'h0000, 8'h00, 1'b0);
    add_cmd(22, 16'h0000, 8'h00, 1'b0);
    add_cmd(29, 16'h0009, 8'h00, 1'b0);
    add_cmd(29, 16'h0005, 8'h00, 1'b0);
    add_cmd(27, 16'h0028, 8'hff, 1'b0);
    add_cmd(27, 16'h0000, 8'h00, 1'b0);
    add_cmd(32, 16'h00ff, 8'h00, 1'b0);
    add_cmd(35, 16'h0004, 8'h00, 1'b0);
    add_cmd(41, 16'h0000, 8'h00, 1'b0);
    add_cmd(42, 16'h0003, 8'h00, 1'b0);
    add_cmd(45, 16'hffff, 8'h00, 1'b1);
    add_cmd(45, 16'hffff, 8'h00, 1'b0);
    add_cmd(46, 16'd36000, 8'h00, 1'b1);
    add_cmd(46, 16'd35999, 8'h00, 1'b1);
    add_cmd(47, 16'hffff, 8'h00, 1'b0);
    add_cmd(51, 16'h0000, 8'h00, 1'b0);
    add_cmd(53, 16'h0000, 8'h00, 1'b0);
    add_cmd(63, 16'hffff, 8'hff, 1'b1);
    wait_drained();

    set_address(8'hff);
    for (int i = 0; i < OpCount; i++) begin
      next_cmd    = random_command();
      next_cmd.op = 6'(i);
      cmd_q.insert(cmd_q.size(), next_cmd);
    end
    add_random(25);
    wait_drained();

    send_idle = 46;
    recv_idle = 32;
    set_address(8'h00);
    add_random(70);
    wait_drained();

    send_idle = 0;
    recv_idle = 0;
    set_address(8'($urandom_range(254, 2)));
    add_random(65);
    @(posedge clk);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    wait_drained();

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
